// ----- src/triple_set_overlap_counter_unit_assert.svh -----
// Assertion macros used by the triple set overlap counter sequencer (tsoc_ctrl).
`ifndef TRIPLE_SET_OVERLAP_COUNTER_UNIT_ASSERT_SVH
`define TRIPLE_SET_OVERLAP_COUNTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSOC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("tsoc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TSOC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("tsoc assertion failed");

`endif

// ----- src/tsoc_pkg.sv -----
// Package with widths, codes and constants of the triple set overlap counter.
package tsoc_pkg;

	localparam int CMD_W    = 2;
	localparam int GENE_W   = 10;
	localparam int SAMPLE_W = 10;
	localparam int LEVEL_W  = 32;
	localparam int COUNT_W  = 28;
	localparam int GCNT_W   = 11;
	localparam int SPLIT_W  = 9;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;
	localparam int WORD_W   = 64;

	localparam logic [CMD_W-1:0] CMD_LOAD     = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RUN      = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd2;
	localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_GENE_COUNT  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TUMOR_SPLIT = 1'b1;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef logic [WORD_W-1:0] word_t;

endpackage

// ----- src/tsoc_if.sv -----
// Channel interfaces: command items, result items and configuration writes.
interface tsoc_cmd_if;
	logic                                  valid;
	logic                                  ready;
	logic [tsoc_pkg::CMD_W-1:0]            command;
	logic [tsoc_pkg::GENE_W-1:0]           gene_index;
	logic [tsoc_pkg::SAMPLE_W-1:0]         sample_index;
	logic signed [tsoc_pkg::LEVEL_W-1:0]   level;
	modport source (output valid, command, gene_index, sample_index, level, input ready);
	modport sink (input valid, command, gene_index, sample_index, level, output ready);
endinterface

interface tsoc_res_if;
	logic                         valid;
	logic                         ready;
	logic [tsoc_pkg::COUNT_W-1:0] triple_count;
	modport source (output valid, triple_count, input ready);
	modport sink (input valid, triple_count, output ready);
endinterface

interface tsoc_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [tsoc_pkg::CFG_IDX_W-1:0]  index;
	logic [tsoc_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- src/tsoc_store.sv -----
// Single-port bitmap memory with registered read data.
module tsoc_store #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   addr,
	input  tsoc_pkg::word_t wdata,
	output tsoc_pkg::word_t rdata
);

	tsoc_pkg::word_t mem [DEPTH];
	tsoc_pkg::word_t rdata_q;

	// One access per cycle: a write when we is set, and the old word read into the output register.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

// ----- src/tsoc_ctrl.sv -----
// Sequencer: loads, clears and the triple walk over one shared AND/compare unit.
`include "triple_set_overlap_counter_unit_assert.svh"

module tsoc_ctrl #(
	parameter int MAX_GENES    = 1024,
	parameter int SAMPLE_WORDS = 4,
	parameter int DEPTH        = MAX_GENES * SAMPLE_WORDS,
	parameter int AW           = $clog2(DEPTH)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	tsoc_cmd_if.sink                      cmd,
	tsoc_res_if.source                    res,
	input  logic [tsoc_pkg::GCNT_W-1:0]   gene_count,
	input  logic [tsoc_pkg::SPLIT_W-1:0]  tumor_split,
	output logic                          mem_we,
	output logic [AW-1:0]                 mem_addr,
	output tsoc_pkg::word_t               mem_wdata,
	input  tsoc_pkg::word_t               mem_rdata
);

	localparam int GCW = $clog2(MAX_GENES) + 2;
	localparam int WIW = (SAMPLE_WORDS > 1) ? $clog2(SAMPLE_WORDS) : 1;

	typedef enum logic [3:0] {
		ST_CLR, ST_IDLE, ST_LD_RD, ST_LD_WR, ST_PAIR, ST_P_RA, ST_P_RB, ST_P_RC,
		ST_P_END, ST_TRI, ST_T_RD, ST_T_CMP, ST_DONE
	} state_t;

	state_t                       state_q;
	logic [AW-1:0]                clr_q;
	logic [AW-1:0]                ld_addr_q;
	logic [5:0]                   ld_bit_q;
	logic [GCW-1:0]               n_q, a_q, b_q, c_q;
	logic [WIW-1:0]               w_q;
	logic                         any_q;
	tsoc_pkg::word_t              tmp_q;
	tsoc_pkg::word_t              ov_q [SAMPLE_WORDS];
	logic [tsoc_pkg::COUNT_W-1:0] total_q;
	logic                         out_valid_q;
	logic [tsoc_pkg::COUNT_W-1:0] out_count_q;

	logic                         accept;
	logic                         ld_ok;
	logic                         w_last;
	tsoc_pkg::word_t              and_op;
	tsoc_pkg::word_t              and_res;
	logic                         and_nz;

	function automatic logic [AW-1:0] word_addr(input logic [GCW-1:0] g,
		input logic [WIW-1:0] w);
		word_addr = AW'(AW'(g) * AW'(SAMPLE_WORDS)) + AW'(w);
	endfunction

	assign cmd.ready = (state_q == ST_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign res.valid = out_valid_q;
	assign res.triple_count = out_count_q;
	assign w_last    = (w_q == WIW'(SAMPLE_WORDS - 1));

	// A record counts only when positive, inside the tumor split and inside the store.
	assign ld_ok = !cmd.level[tsoc_pkg::LEVEL_W-1] && (cmd.level != '0)
		&& (32'(cmd.sample_index) < 32'(tumor_split))
		&& (32'(cmd.sample_index) < 32'(SAMPLE_WORDS * 64))
		&& (32'(cmd.gene_index) < 32'(MAX_GENES));

	// Shared unit: intersect a memory word with the held operand and test for any bit.
	assign and_op  = (state_q == ST_P_RC) ? tmp_q : ov_q[w_q];
	assign and_res = and_op & mem_rdata;
	assign and_nz  = (and_res != '0);

	// Memory port selection.
	always_comb begin
		mem_we    = 1'b0;
		mem_wdata = '0;
		unique case (state_q)
			ST_CLR: begin
				mem_we   = 1'b1;
				mem_addr = clr_q;
			end
			ST_LD_RD: mem_addr = ld_addr_q;
			ST_LD_WR: begin
				mem_we    = 1'b1;
				mem_addr  = ld_addr_q;
				mem_wdata = mem_rdata | (tsoc_pkg::word_t'(1) << ld_bit_q);
			end
			ST_P_RA: mem_addr = word_addr(a_q, w_q);
			ST_P_RB: mem_addr = word_addr(b_q, w_q);
			ST_T_RD: mem_addr = word_addr(c_q, w_q);
			default: mem_addr = '0;
		endcase
	end

	// Sequencer state and registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			total_q     <= '0;
		end else begin
			if (res.valid && res.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						ld_addr_q <= AW'(AW'(cmd.gene_index) * AW'(SAMPLE_WORDS))
							+ AW'(cmd.sample_index[9:6]);
						ld_bit_q  <= cmd.sample_index[5:0];
						if (cmd.command == tsoc_pkg::CMD_LOAD) begin
							if (ld_ok) begin
								state_q <= ST_LD_RD;
							end
						end else if (cmd.command == tsoc_pkg::CMD_RUN) begin
							if (32'(gene_count) > 32'(MAX_GENES)) begin
								n_q <= GCW'(MAX_GENES);
							end else begin
								n_q <= GCW'(gene_count);
							end
							a_q     <= '0;
							b_q     <= GCW'(1);
							total_q <= '0;
							state_q <= ST_PAIR;
						end else if (cmd.command == tsoc_pkg::CMD_CLEAR) begin
							clr_q   <= '0;
							state_q <= ST_CLR;
						end
					end
				end
				ST_LD_RD: state_q <= ST_LD_WR;
				ST_LD_WR: state_q <= ST_IDLE;
				ST_PAIR: begin
					w_q   <= '0;
					any_q <= 1'b0;
					if (b_q < n_q) begin
						state_q <= ST_P_RA;
					end else if (a_q + GCW'(1) < n_q) begin
						a_q <= a_q + GCW'(1);
						b_q <= a_q + GCW'(2);
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_P_RA: state_q <= ST_P_RB;
				ST_P_RB: begin
					tmp_q   <= mem_rdata;
					state_q <= ST_P_RC;
				end
				ST_P_RC: begin
					ov_q[w_q] <= and_res;
					any_q     <= any_q | and_nz;
					if (w_last) begin
						state_q <= ST_P_END;
					end else begin
						w_q     <= w_q + WIW'(1);
						state_q <= ST_P_RA;
					end
				end
				ST_P_END: begin
					if (any_q) begin
						c_q     <= b_q + GCW'(1);
						state_q <= ST_TRI;
					end else begin
						b_q     <= b_q + GCW'(1);
						state_q <= ST_PAIR;
					end
				end
				ST_TRI: begin
					w_q <= '0;
					if (c_q < n_q) begin
						state_q <= ST_T_RD;
					end else begin
						b_q     <= b_q + GCW'(1);
						state_q <= ST_PAIR;
					end
				end
				ST_T_RD: state_q <= ST_T_CMP;
				ST_T_CMP: begin
					if (and_nz || w_last) begin
						if (and_nz && total_q != tsoc_pkg::COUNT_MAX) begin
							total_q <= total_q + tsoc_pkg::COUNT_W'(1);
						end
						c_q     <= c_q + GCW'(1);
						state_q <= ST_TRI;
					end else begin
						w_q     <= w_q + WIW'(1);
						state_q <= ST_T_RD;
					end
				end
				ST_DONE: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						out_count_q <= total_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`TSOC_ASSERT_IMP(a_pair_order, clk, arst_n, state_q == ST_P_RA, (a_q < b_q) && (b_q < n_q))
	`TSOC_ASSERT_IMP(a_tri_order, clk, arst_n, state_q == ST_T_RD, (b_q < c_q) && (c_q < n_q))
	`TSOC_ASSERT_IMP(a_we_src, clk, arst_n, mem_we, (state_q == ST_CLR) || (state_q == ST_LD_WR))
	`TSOC_ASSERT_NXT(a_result_from_run, clk, arst_n, !out_valid_q && state_q != ST_DONE,
		!out_valid_q)

endmodule

// ----- src/triple_set_overlap_counter_unit.sv -----
// Top level of the triple set overlap counter: configuration, store and sequencer.
//
// Channels: cmd takes items (command, gene_index, sample_index, level) by
// valid/ready; res gives one triple_count item per run command; cfg writes
// register 0 (gene_count) or 1 (tumor_split) and is always ready.
// A load item that sets a bit goes through a read state and then a write state,
// as the single memory port does a read, then a write of the merged word.
// A clear item clears all MAX_GENES*SAMPLE_WORDS words, one word cleared a cycle.
// An ignored load leaves the block idle. A run item walks the gene pairs among
// the first gene_count genes (at most MAX_GENES): per sample word a pair reads
// both bitmaps and ANDs them, and a pair whose bitmaps intersect goes on to its
// triples; each triple reads the third gene's words until a common bit is found.
// After reset the block clears the whole store and accepts no item meanwhile;
// the configuration registers, result valid and running total reset to zero.
// The result waits in an output register while res is stalled; the block goes
// on taking load and clear items, and a following run holds its result until
// the earlier one is taken.
module triple_set_overlap_counter_unit #(
	parameter int MAX_GENES    = 1024,
	parameter int SAMPLE_WORDS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	tsoc_cmd_if.sink    cmd,
	tsoc_res_if.source  res,
	tsoc_cfg_if.sink    cfg
);

	localparam int DEPTH = MAX_GENES * SAMPLE_WORDS;
	localparam int AW    = $clog2(DEPTH);

	logic [tsoc_pkg::GCNT_W-1:0]  gene_count_q;
	logic [tsoc_pkg::SPLIT_W-1:0] tumor_split_q;
	logic                         mem_we;
	logic [AW-1:0]                mem_addr;
	tsoc_pkg::word_t              mem_wdata;
	tsoc_pkg::word_t              mem_rdata;

	assign cfg.ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gene_count_q  <= '0;
			tumor_split_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				tsoc_pkg::CFG_GENE_COUNT:  gene_count_q  <= cfg.data;
				tsoc_pkg::CFG_TUMOR_SPLIT: tumor_split_q <= cfg.data[tsoc_pkg::SPLIT_W-1:0];
				default: ;
			endcase
		end
	end

	tsoc_ctrl #(
		.MAX_GENES    (MAX_GENES),
		.SAMPLE_WORDS (SAMPLE_WORDS),
		.DEPTH        (DEPTH),
		.AW           (AW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.res         (res),
		.gene_count  (gene_count_q),
		.tumor_split (tumor_split_q),
		.mem_we      (mem_we),
		.mem_addr    (mem_addr),
		.mem_wdata   (mem_wdata),
		.mem_rdata   (mem_rdata)
	);

	tsoc_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

endmodule
